>>> hdl/ymr_pkg.sv
// ymr_pkg: shared constants, types and the CRC-16 byte update for the
// YMODEM packet receiver. No dependencies.
package ymr_pkg;

  localparam int SHORT_BLOCK = 128;
  localparam int LONG_BLOCK  = 1024;
  localparam int IDX_W       = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  C_SOH    = 8'h01;
  localparam logic [7:0]  C_STX    = 8'h02;
  localparam logic [7:0]  C_EOT    = 8'h04;
  localparam logic [7:0]  C_CAN    = 8'h18;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [3:0] {
    K_DATA    = 4'd0,
    K_OK      = 4'd1,
    K_EOT     = 4'd2,
    K_CANCEL  = 4'd3,
    K_BADCMD  = 4'd4,
    K_BADSEQ  = 4'd5,
    K_BADCRC  = 4'd6,
    K_TIMEOUT = 4'd7,
    K_LONECAN = 4'd8
  } kind_t;

  // work handed from the framer to the CRC/result stage
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_DATA,
    OP_FEED,
    OP_CHECK,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    kind_t            kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic [7:0]       seq;
    logic             long_blk;
    logic             seq_ok;
  } op_pkt_t;

  // CRC-16/XMODEM, MSB first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> hdl/ymr_if.sv
// ymr_if: valid/ready channel interfaces for line events and results.
// Depends on ymr_pkg.
interface ymr_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface ymr_res_if;
  logic                      valid;
  logic                      ready;
  logic [3:0]                kind;
  logic [7:0]                payload_byte;
  logic [ymr_pkg::IDX_W-1:0] byte_index;
  logic [7:0]                block_sequence;
  logic                      long_block;
  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output block_sequence, output long_block, input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_index,
                  input block_sequence, input long_block, output ready);
endinterface

>>> hdl/ymr_fifo.sv
// ymr_fifo: small register FIFO between the framer and the result stage.
// No package dependency.
module ymr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        mem[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end
endmodule

>>> hdl/ymr_front.sv
// ymr_front: packet framer. Tracks the packet phase, classifies each line
// event and pushes one work packet per transaction. Depends on ymr_pkg.
module ymr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [7:0]       rx_byte,
  output logic             push,
  output ymr_pkg::op_pkt_t push_op,
  input  logic             q_full
);
  import ymr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SEQ  = 3'd1,
    PH_SEQC = 3'd2,
    PH_DATA = 3'd3,
    PH_CRCH = 3'd4,
    PH_CRCL = 3'd5,
    PH_CANW = 3'd6
  } phase_t;

  localparam logic [IDX_W:0] SIZE_SHORT = (IDX_W + 1)'(SHORT_BLOCK);
  localparam logic [IDX_W:0] SIZE_LONG  = (IDX_W + 1)'(LONG_BLOCK);

  phase_t           phase, phase_next;
  logic             long_mode, long_mode_next;
  logic [IDX_W-1:0] payload_count, payload_count_next;
  logic [7:0]       seq_value, seq_value_next;
  logic [7:0]       seq_complement, seq_complement_next;
  logic             last_byte;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  assign last_byte = ({1'b0, payload_count} + 1'b1) >= (long_mode ? SIZE_LONG : SIZE_SHORT);

  always_comb begin
    phase_next          = phase;
    long_mode_next      = long_mode;
    payload_count_next  = payload_count;
    seq_value_next      = seq_value;
    seq_complement_next = seq_complement;
    push_op.op          = OP_NONE;
    push_op.kind        = K_TIMEOUT;
    push_op.data        = rx_byte;
    push_op.index       = '0;
    push_op.seq         = '0;
    push_op.long_blk    = 1'b0;
    push_op.seq_ok      = (seq_value == ~seq_complement);
    if (action) begin
      phase_next   = PH_IDLE;
      push_op.op   = OP_EMIT;
      push_op.kind = (phase == PH_CANW) ? K_LONECAN : K_TIMEOUT;
    end else begin
      unique case (phase)
        PH_SEQ: begin
          seq_value_next = rx_byte;
          phase_next     = PH_SEQC;
        end
        PH_SEQC: begin
          seq_complement_next = rx_byte;
          phase_next          = PH_DATA;
        end
        PH_DATA: begin
          push_op.op       = OP_DATA;
          push_op.kind     = K_DATA;
          push_op.index    = payload_count;
          push_op.seq      = seq_value;
          push_op.long_blk = long_mode;
          if (last_byte) begin
            payload_count_next = '0;
            phase_next         = PH_CRCH;
          end else begin
            payload_count_next = payload_count + 1'b1;
          end
        end
        PH_CRCH: begin
          push_op.op = OP_FEED;
          phase_next = PH_CRCL;
        end
        PH_CRCL: begin
          push_op.op       = OP_CHECK;
          push_op.kind     = K_OK;
          push_op.seq      = seq_value;
          push_op.long_blk = long_mode;
          phase_next       = PH_IDLE;
        end
        PH_CANW: begin
          push_op.op   = OP_EMIT;
          push_op.kind = (rx_byte == C_CAN) ? K_CANCEL : K_LONECAN;
          phase_next   = PH_IDLE;
        end
        default: begin
          // idle, and any stray phase code
          phase_next = PH_IDLE;
          if (rx_byte == C_SOH || rx_byte == C_STX) begin
            long_mode_next     = (rx_byte == C_STX);
            payload_count_next = '0;
            push_op.op         = OP_START;
            phase_next         = PH_SEQ;
          end else if (rx_byte == C_EOT) begin
            push_op.op   = OP_EMIT;
            push_op.kind = K_EOT;
          end else if (rx_byte == C_CAN) begin
            phase_next = PH_CANW;
          end else begin
            push_op.op   = OP_EMIT;
            push_op.kind = K_BADCMD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      long_mode      <= 1'b0;
      payload_count  <= '0;
      seq_value      <= '0;
      seq_complement <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      long_mode      <= long_mode_next;
      payload_count  <= payload_count_next;
      seq_value      <= seq_value_next;
      seq_complement <= seq_complement_next;
    end
  end
endmodule

>>> hdl/ymr_back.sv
// ymr_back: CRC accumulator and result register. Pops work packets from the
// queue and drives the result channel. Depends on ymr_pkg.
module ymr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  ymr_pkg::op_pkt_t    q_op,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          kind,
  output logic [7:0]          payload_byte,
  output logic [ymr_pkg::IDX_W-1:0] byte_index,
  output logic [7:0]          block_sequence,
  output logic                long_block
);
  import ymr_pkg::*;

  logic [15:0] crc_register;
  logic [15:0] crc_fed;
  logic        advance;
  logic        has_result;
  kind_t       res_kind;

  assign advance = !out_valid || out_ready;
  assign q_pop   = q_valid && advance;
  assign crc_fed = crc_feed(crc_register, q_op.data);

  always_comb begin
    has_result = 1'b0;
    res_kind   = q_op.kind;
    case (q_op.op)
      OP_DATA, OP_EMIT: has_result = 1'b1;
      OP_CHECK: begin
        has_result = 1'b1;
        // sequence mismatch wins over a CRC failure
        if (!q_op.seq_ok)          res_kind = K_BADSEQ;
        else if (crc_fed != 16'h0) res_kind = K_BADCRC;
        else                       res_kind = K_OK;
      end
      default: has_result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      crc_register <= '0;
    end else begin
      if (q_pop) begin
        case (q_op.op)
          OP_START:                   crc_register <= '0;
          OP_DATA, OP_FEED, OP_CHECK: crc_register <= crc_fed;
          default:                    crc_register <= crc_register;
        endcase
      end
      if (advance) begin
        out_valid <= q_valid && has_result;
        if (q_valid && has_result) begin
          kind           <= res_kind;
          payload_byte   <= (q_op.op == OP_DATA) ? q_op.data : 8'h00;
          byte_index     <= (q_op.op == OP_DATA) ? q_op.index : '0;
          block_sequence <= q_op.seq;
          long_block     <= q_op.long_blk;
        end
      end
    end
  end
endmodule

>>> hdl/ymodem_packet_receiver.sv
// Channel   | Dir | Payload                                              | Handshake
// request   | in  | action, rx_byte                                      | valid/ready
// result    | out | kind, payload_byte, byte_index, block_sequence, long | valid/ready
//
// One line event per cycle while the queue has room; the framer phase register
// closes its loop within the framer and the CRC update (one byte through an 8-step
// table-free unroll) closes in the result stage. A result is written into the
// queue at the accepting edge and into the result register once it is popped.
// Reset (rst, synchronous) clears the phase, the queue, the CRC and result valid.
// A stalled result holds the result register; the queue then fills and request
// ready drops once it holds QUEUE_DEPTH work packets.
module ymodem_packet_receiver #(
  parameter int QUEUE_DEPTH = ymr_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  ymr_req_if.sink   request,
  ymr_res_if.source result
);
  import ymr_pkg::*;

  localparam int OP_W = $bits(op_pkt_t);

  logic    push;
  op_pkt_t push_op;
  logic    q_full;
  logic    q_valid;
  op_pkt_t q_op;
  logic    q_pop;

  ymr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .action   (request.action),
    .rx_byte  (request.rx_byte),
    .push     (push),
    .push_op  (push_op),
    .q_full   (q_full)
  );

  ymr_fifo #(
    .WIDTH (OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_op),
    .not_empty (q_valid)
  );

  ymr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .kind           (result.kind),
    .payload_byte   (result.payload_byte),
    .byte_index     (result.byte_index),
    .block_sequence (result.block_sequence),
    .long_block     (result.long_block)
  );
endmodule

>>> hdl/ymr_checker.sv
// ymr_checker: port-level checks on the result channel, bound to the top level.
// Depends on ymr_pkg and ymodem_packet_receiver.
module ymr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [3:0]                kind,
  input logic [7:0]                payload_byte,
  input logic [ymr_pkg::IDX_W-1:0] byte_index,
  input logic [7:0]                block_sequence,
  input logic                      long_block
);
  import ymr_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(payload_byte)
      && $stable(byte_index) && $stable(block_sequence) && $stable(long_block))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != K_DATA |-> payload_byte == 8'h00 && byte_index == '0)
    else $error("payload fields set on a status result");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == K_EOT || kind == K_CANCEL || kind == K_BADCMD
      || kind == K_TIMEOUT || kind == K_LONECAN)
      |-> block_sequence == 8'h00 && !long_block)
    else $error("block fields set on a non-packet result");
endmodule

bind ymodem_packet_receiver ymr_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .kind           (result.kind),
  .payload_byte   (result.payload_byte),
  .byte_index     (result.byte_index),
  .block_sequence (result.block_sequence),
  .long_block     (result.long_block)
);
